FILE: hw/rtl/i2cms_pkg.sv
`timescale 1ns / 1ps

package i2cms_pkg;

  // Opcodes carried on the input channel.
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [7:0] ACK_WAIT_RESET = 8'd30;

  typedef enum logic [4:0] {
    CMD_IDLE  = 5'b00001,
    CMD_START = 5'b00010,
    CMD_STOP  = 5'b00100,
    CMD_WRITE = 5'b01000,
    CMD_READ  = 5'b10000
  } cmd_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ack_seen;
    logic [7:0] rx_byte;
    logic       rejected;
  } res_t;

endpackage

FILE: hw/rtl/i2cms_core.sv
`timescale 1ns / 1ps

module i2cms_core import i2cms_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       step_en,
  input  logic [2:0] opcode,
  input  logic [7:0] tx_byte,
  input  logic       send_ack,
  input  logic       sda_in,
  output res_t       res
);

  localparam logic [5:0] ST_SDA_LOW  = 6'd4;
  localparam logic [5:0] ST_END      = 6'd8;
  localparam logic [5:0] SP_SDA_LOW  = 6'd1;
  localparam logic [5:0] SP_SCL_HI   = 6'd5;
  localparam logic [5:0] SP_END      = 6'd6;
  localparam logic [5:0] WR_BITS_END = 6'd24;
  localparam logic [5:0] WR_REL      = 6'd25;
  localparam logic [5:0] WR_SCL_HI   = 6'd26;
  localparam logic [5:0] WR_POLL     = 6'd27;
  localparam logic [5:0] WR_HOLD     = 6'd28;
  localparam logic [5:0] RD_BITS_END = 6'd16;
  localparam logic [5:0] RD_LAST_BIT = 6'd15;
  localparam logic [5:0] RD_ACK      = 6'd17;
  localparam logic [5:0] RD_SCL_HI   = 6'd18;

  logic [7:0] ack_wait_r;
  cmd_t       cmd_r, cmd_nxt;
  logic [5:0] phase_r, phase_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_r, ack_nxt;
  logic       ackc_r, ackc_nxt;
  logic [7:0] rx_r, rx_nxt;

  logic       is_cmd;
  cmd_t       op_cmd;
  logic       fin;
  logic       rej;
  logic       hold_phase;
  logic [7:0] limit;

  always_comb begin
    is_cmd = 1'b1;
    op_cmd = CMD_IDLE;
    case (opcode)
      OP_START: op_cmd = CMD_START;
      OP_STOP:  op_cmd = CMD_STOP;
      OP_WRITE: op_cmd = CMD_WRITE;
      OP_READ:  op_cmd = CMD_READ;
      OP_TICK:  is_cmd = 1'b0;
      default:  is_cmd = 1'b0;
    endcase
  end

  assign limit = (ack_wait_r == 8'd0) ? 8'd1 : ack_wait_r;

  always_comb begin
    cmd_nxt    = cmd_r;
    phase_nxt  = phase_r;
    sub_nxt    = sub_r;
    shift_nxt  = shift_r;
    wait_nxt   = wait_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    ack_nxt    = ack_r;
    ackc_nxt   = ackc_r;
    rx_nxt     = rx_r;
    fin        = 1'b0;
    hold_phase = 1'b0;
    rej        = 1'b0;

    // A new command loads the sequence state; its item is also tick zero.
    if (cmd_r == CMD_IDLE) begin
      if (is_cmd) begin
        cmd_nxt   = op_cmd;
        phase_nxt = 6'd0;
        sub_nxt   = 2'd0;
        wait_nxt  = 8'd0;
        if (op_cmd == CMD_WRITE) begin
          shift_nxt = tx_byte;
        end
        if (op_cmd == CMD_READ) begin
          shift_nxt = 8'd0;
          ackc_nxt  = send_ack;
        end
      end
    end else if (is_cmd) begin
      rej = 1'b1;
    end

    case (cmd_nxt)
      CMD_START: begin
        if (phase_nxt == 6'd0) begin
          sda_nxt = 1'b1;
          scl_nxt = 1'b1;
        end else if (phase_nxt == ST_SDA_LOW) begin
          sda_nxt = 1'b0;
        end
        fin = (phase_nxt >= ST_END);
      end
      CMD_STOP: begin
        if (phase_nxt == 6'd0) begin
          scl_nxt = 1'b0;
        end else if (phase_nxt == SP_SDA_LOW) begin
          sda_nxt = 1'b0;
        end else if (phase_nxt == SP_SCL_HI) begin
          scl_nxt = 1'b1;
        end else if (phase_nxt >= SP_END) begin
          sda_nxt = 1'b1;
          fin     = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (phase_nxt < WR_BITS_END) begin
          // sub tracks the position within the three ticks of one bit.
          sub_nxt = (sub_nxt == 2'd2) ? 2'd0 : sub_nxt + 2'd1;
          if (sub_r == 2'd0 || cmd_r == CMD_IDLE) begin
            scl_nxt = 1'b0;
          end else if (sub_r == 2'd1) begin
            sda_nxt   = shift_nxt[7];
            shift_nxt = {shift_nxt[6:0], 1'b0};
          end else begin
            scl_nxt = 1'b1;
          end
        end else if (phase_nxt == WR_BITS_END) begin
          scl_nxt = 1'b0;
        end else if (phase_nxt == WR_REL) begin
          sda_nxt = 1'b1;
        end else if (phase_nxt == WR_SCL_HI) begin
          scl_nxt = 1'b1;
        end else if (phase_nxt == WR_POLL) begin
          wait_nxt   = wait_nxt + 8'd1;
          hold_phase = 1'b1;
          if (!sda_in) begin
            ack_nxt   = 1'b1;
            scl_nxt   = 1'b0;
            phase_nxt = WR_HOLD;
          end else if (wait_nxt >= limit) begin
            ack_nxt = 1'b0;
            scl_nxt = 1'b0;
            fin     = 1'b1;
          end
        end else begin
          fin = 1'b1;
        end
      end
      CMD_READ: begin
        if (phase_nxt < RD_BITS_END) begin
          if (phase_nxt == 6'd0) begin
            sda_nxt = 1'b1;
          end
          if (!phase_nxt[0]) begin
            scl_nxt = 1'b0;
          end else begin
            scl_nxt   = 1'b1;
            shift_nxt = {shift_nxt[6:0], sda_in};
            if (phase_nxt == RD_LAST_BIT) begin
              rx_nxt = shift_nxt;
            end
          end
        end else if (phase_nxt == RD_BITS_END) begin
          scl_nxt = 1'b0;
        end else if (phase_nxt == RD_ACK) begin
          sda_nxt = ~ackc_nxt;
        end else if (phase_nxt == RD_SCL_HI) begin
          scl_nxt = 1'b1;
        end else begin
          scl_nxt = 1'b0;
          fin     = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (fin) begin
      cmd_nxt   = CMD_IDLE;
      phase_nxt = 6'd0;
    end else if (cmd_nxt != CMD_IDLE && !hold_phase) begin
      phase_nxt = phase_nxt + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_wait_r <= ACK_WAIT_RESET;
      cmd_r      <= CMD_IDLE;
      phase_r    <= 6'd0;
      sub_r      <= 2'd0;
      shift_r    <= 8'd0;
      wait_r     <= 8'd0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      ack_r      <= 1'b0;
      ackc_r     <= 1'b0;
      rx_r       <= 8'd0;
    end else begin
      if (cfg_we) begin
        ack_wait_r <= cfg_wdata;
      end
      if (step_en) begin
        cmd_r   <= cmd_nxt;
        phase_r <= phase_nxt;
        sub_r   <= sub_nxt;
        shift_r <= shift_nxt;
        wait_r  <= wait_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        ack_r   <= ack_nxt;
        ackc_r  <= ackc_nxt;
        rx_r    <= rx_nxt;
      end
    end
  end

  always_comb begin
    res.scl_out  = scl_nxt;
    res.sda_out  = sda_nxt;
    res.busy_res = (cmd_nxt != CMD_IDLE);
    res.done_res = fin;
    res.ack_seen = ack_nxt;
    res.rx_byte  = rx_nxt;
    res.rejected = rej;
  end

endmodule

FILE: hw/rtl/i2c_master_bit_sequencer_unit.sv
`timescale 1ns / 1ps

// I2C master bit sequencer. Each input item is one bus tick: it may carry a
// START, STOP, WRITE_BYTE or READ_BYTE command (taken only while idle, else
// flagged as rejected) and the sampled SDA level, and it yields exactly one
// result item with the SCL/SDA drive levels and status after that tick. One
// item is accepted per clock while the output is not stalled; an item is held in
// the input register and its result in the result register, around the
// combinational sequencer step. cfg_we writes ack_wait_ticks (reset 30).
module i2c_master_bit_sequencer_unit import i2cms_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_opcode,
  input  logic [7:0] in_tx_byte,
  input  logic       in_send_ack,
  input  logic       in_sda_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_out,
  output logic       out_sda_out,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic       out_ack_seen,
  output logic [7:0] out_rx_byte,
  output logic       out_rejected
);

  logic       in_v_r;
  logic [2:0] op_r;
  logic [7:0] tx_r;
  logic       sack_r;
  logic       sda_r;
  logic       out_v_r;
  res_t       res_r;
  res_t       res;
  logic       adv;
  logic       step_en;

  // The result register is free when empty or being taken this cycle.
  assign adv      = !out_v_r || !out_stall;
  assign step_en  = in_v_r && adv;
  assign in_stall = in_v_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= step_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r   <= in_opcode;
      tx_r   <= in_tx_byte;
      sack_r <= in_send_ack;
      sda_r  <= in_sda_in;
    end
    if (step_en) begin
      res_r <= res;
    end
  end

  i2cms_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step_en   (step_en),
    .opcode    (op_r),
    .tx_byte   (tx_r),
    .send_ack  (sack_r),
    .sda_in    (sda_r),
    .res       (res)
  );

  assign out_valid    = out_v_r;
  assign out_scl_out  = res_r.scl_out;
  assign out_sda_out  = res_r.sda_out;
  assign out_busy_res = res_r.busy_res;
  assign out_done_res = res_r.done_res;
  assign out_ack_seen = res_r.ack_seen;
  assign out_rx_byte  = res_r.rx_byte;
  assign out_rejected = res_r.rejected;

endmodule

FILE: bench/i2c_master_bit_sequencer_unit_tb.sv
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_unit_tb;
  import i2cms_pkg::*;

  localparam int POLL_TICK    = 27;
  localparam int HOLD_TICK    = 28;
  localparam int IDLE_PCT     = 38;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_ITEMS  = 195;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] txb;
    logic       sack;
    logic       sda;
  } tick_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_opcode = OP_TICK;
  logic [7:0] in_tx_byte = 8'd0;
  logic       in_send_ack = 1'b0;
  logic       in_sda_in = 1'b1;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_scl_out;
  logic       out_sda_out;
  logic       out_busy_res;
  logic       out_done_res;
  logic       out_ack_seen;
  logic [7:0] out_rx_byte;
  logic       out_rejected;

  // Bus state as the sequencer should hold it.
  cmd_t       bus_cmd = CMD_IDLE;
  logic [5:0] seq_tick = '0;
  logic [7:0] shifter = '0;
  logic [7:0] poll_count = '0;
  logic       scl_lvl = 1'b1;
  logic       sda_lvl = 1'b1;
  logic       ack_lvl = 1'b0;
  logic       ack_pick = 1'b0;
  logic [7:0] rx_lvl = '0;
  logic [7:0] ack_limit = ACK_WAIT_RESET;

  tick_item_t pending_ticks[$];
  res_t       bus_results[$];
  tick_item_t next_tick;
  res_t       seen_res;
  res_t       want_res;
  int         items_queued = 0;
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  int         hold_left = 0;
  bit         hold_req = 1'b0;
  bit         steady = 1'b0;

  i2c_master_bit_sequencer_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .in_tx_byte  (in_tx_byte),
    .in_send_ack (in_send_ack),
    .in_sda_in   (in_sda_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_scl_out (out_scl_out),
    .out_sda_out (out_sda_out),
    .out_busy_res(out_busy_res),
    .out_done_res(out_done_res),
    .out_ack_seen(out_ack_seen),
    .out_rx_byte (out_rx_byte),
    .out_rejected(out_rejected)
  );

  always #2 clk = ~clk;

  // Advances the bus by one tick and returns the line levels and status.
  function automatic res_t bus_step(logic [2:0] op, logic [7:0] txb, logic sack,
                                    logic sda);
    res_t       r;
    logic       is_cmd;
    logic       rej;
    logic       fin;
    logic       advance;
    logic [5:0] p;
    logic [7:0] lim;
    is_cmd  = (op >= OP_START) && (op <= OP_READ);
    rej     = 1'b0;
    fin     = 1'b0;
    advance = 1'b1;
    if (bus_cmd == CMD_IDLE) begin
      if (is_cmd) begin
        seq_tick   = '0;
        poll_count = '0;
        case (op)
          OP_START: bus_cmd = CMD_START;
          OP_STOP:  bus_cmd = CMD_STOP;
          OP_WRITE: begin
            bus_cmd = CMD_WRITE;
            shifter = txb;
          end
          default: begin
            bus_cmd  = CMD_READ;
            shifter  = '0;
            ack_pick = sack;
          end
        endcase
      end
    end else if (is_cmd) begin
      rej = 1'b1;
    end
    if (bus_cmd != CMD_IDLE) begin
      p = seq_tick;
      case (bus_cmd)
        CMD_START: begin
          if (p == 0) begin
            sda_lvl = 1'b1;
            scl_lvl = 1'b1;
          end else if (p == 4) begin
            sda_lvl = 1'b0;
          end
          fin = (p >= 8);
        end
        CMD_STOP: begin
          if (p == 0) scl_lvl = 1'b0;
          else if (p == 1) sda_lvl = 1'b0;
          else if (p == 5) scl_lvl = 1'b1;
          else if (p >= 6) begin
            sda_lvl = 1'b1;
            fin = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (p < 24) begin
            case (p % 3)
              0: scl_lvl = 1'b0;
              1: begin
                sda_lvl = shifter[7];
                shifter = shifter << 1;
              end
              default: scl_lvl = 1'b1;
            endcase
          end else if (p == 24) begin
            scl_lvl = 1'b0;
          end else if (p == 25) begin
            sda_lvl = 1'b1;
          end else if (p == 26) begin
            scl_lvl = 1'b1;
          end else if (p == POLL_TICK) begin
            // The poll tick repeats in place until the slave answers or time runs out.
            advance = 1'b0;
            lim = (ack_limit == 0) ? 8'd1 : ack_limit;
            poll_count = poll_count + 8'd1;
            if (!sda) begin
              ack_lvl = 1'b1;
              scl_lvl = 1'b0;
              seq_tick = 6'(HOLD_TICK);
            end else if (poll_count >= lim) begin
              ack_lvl = 1'b0;
              scl_lvl = 1'b0;
              fin = 1'b1;
            end
          end else begin
            fin = 1'b1;
          end
        end
        default: begin
          if (p < 16) begin
            if (p == 0) sda_lvl = 1'b1;
            if (!p[0]) begin
              scl_lvl = 1'b0;
            end else begin
              scl_lvl = 1'b1;
              shifter = {shifter[6:0], sda};
              if (p == 15) rx_lvl = shifter;
            end
          end else if (p == 16) begin
            scl_lvl = 1'b0;
          end else if (p == 17) begin
            sda_lvl = ack_pick ? 1'b0 : 1'b1;
          end else if (p == 18) begin
            scl_lvl = 1'b1;
          end else begin
            scl_lvl = 1'b0;
            fin = 1'b1;
          end
        end
      endcase
      if (fin) begin
        bus_cmd  = CMD_IDLE;
        seq_tick = '0;
      end else if (advance) begin
        seq_tick = p + 6'd1;
      end
    end
    r.scl_out  = scl_lvl;
    r.sda_out  = sda_lvl;
    r.busy_res = (bus_cmd != CMD_IDLE);
    r.done_res = fin;
    r.ack_seen = ack_lvl;
    r.rx_byte  = rx_lvl;
    r.rejected = rej;
    return r;
  endfunction

  task automatic add_item(logic [2:0] op, logic [7:0] txb, logic sack, logic sda);
    tick_item_t it;
    it.op   = op;
    it.txb  = txb;
    it.sack = sack;
    it.sda  = sda;
    pending_ticks.push_back(it);
    items_queued++;
  endtask

  // A plain tick, or now and then a stray command or an unused opcode.
  task automatic queue_tick(bit noisy);
    logic [2:0] op;
    op = OP_TICK;
    if (noisy && $urandom_range(0, 15) == 0) op = 3'($urandom_range(1, 7));
    add_item(op, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // A command followed by the ticks that should carry it to its end.
  task automatic queue_command(logic [2:0] op);
    int         span;
    int         lim;
    int         ack_at;
    logic [7:0] txb;
    case ($urandom_range(0, 3))
      0:       txb = 8'h00;
      1:       txb = 8'hFF;
      default: txb = 8'($urandom);
    endcase
    add_item(op, txb, 1'($urandom), 1'($urandom));
    case (op)
      OP_START: span = 8;
      OP_STOP:  span = 6;
      OP_READ:  span = 19;
      default:  span = 26;
    endcase
    // Cutting a sequence short makes the next command land while busy.
    if ($urandom_range(0, 9) == 0) span = $urandom_range(0, span);
    repeat (span) queue_tick(1'b1);
    if (op == OP_WRITE && span == 26) begin
      lim = (ack_limit == 0) ? 1 : ack_limit;
      ack_at = ($urandom_range(0, 3) == 0) ? lim + 1 : $urandom_range(1, lim);
      for (int j = 1; j <= lim && j <= ack_at; j++) begin
        add_item(OP_TICK, 8'($urandom), 1'($urandom), j != ack_at);
      end
      if (ack_at <= lim) queue_tick(1'b0);
    end
    repeat ($urandom_range(0, 2)) queue_tick(1'b1);
  endtask

  // Waits until every queued item is in and every result is out.
  task automatic drain_bus();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || bus_results.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_ack_wait(logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    ack_limit = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        bus_results.push_back(bus_step(in_opcode, in_tx_byte, in_send_ack, in_sda_in));
      end
      if (!in_valid || !in_stall) begin
        if (pending_ticks.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
        begin
          next_tick = pending_ticks.pop_front();
          in_valid    <= 1'b1;
          in_opcode   <= next_tick.op;
          in_tx_byte  <= next_tick.txb;
          in_send_ack <= next_tick.sack;
          in_sda_in   <= next_tick.sda;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_res.scl_out  = out_scl_out;
      seen_res.sda_out  = out_sda_out;
      seen_res.busy_res = out_busy_res;
      seen_res.done_res = out_done_res;
      seen_res.ack_seen = out_ack_seen;
      seen_res.rx_byte  = out_rx_byte;
      seen_res.rejected = out_rejected;
      if (bus_results.size() == 0) begin
        $error("result item with no expected result pending");
        mismatch_count++;
      end else begin
        want_res = bus_results.pop_front();
        check_field("scl_out", 8'(want_res.scl_out), 8'(seen_res.scl_out));
        check_field("sda_out", 8'(want_res.sda_out), 8'(seen_res.sda_out));
        check_field("busy_res", 8'(want_res.busy_res), 8'(seen_res.busy_res));
        check_field("done_res", 8'(want_res.done_res), 8'(seen_res.done_res));
        check_field("ack_seen", 8'(want_res.ack_seen), 8'(seen_res.ack_seen));
        check_field("rx_byte", want_res.rx_byte, seen_res.rx_byte);
        check_field("rejected", 8'(want_res.rejected), 8'(seen_res.rejected));
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("i2c_master_bit_sequencer_unit_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] wait_settings[8];
    wait_settings = '{8'd1, 8'd255, 8'd0, 8'd4, 8'd2, 8'd9, 8'd1, 8'd16};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Idle ticks, unused opcodes, STOP, and START with a write landing while busy.
    add_item(OP_TICK, 8'h00, 1'b0, 1'b0);
    add_item(OP_TICK, 8'hFF, 1'b1, 1'b1);
    add_item(3'd5, 8'h00, 1'b0, 1'b1);
    add_item(3'd6, 8'hFF, 1'b1, 1'b0);
    add_item(3'd7, 8'h5A, 1'b0, 1'b1);
    add_item(OP_STOP, 8'h00, 1'b0, 1'b1);
    repeat (6) add_item(OP_TICK, 8'h00, 1'b0, 1'b1);
    add_item(OP_START, 8'h00, 1'b0, 1'b1);
    add_item(OP_TICK, 8'h00, 1'b0, 1'b1);
    add_item(OP_WRITE, 8'hFF, 1'b1, 1'b0);
    repeat (6) add_item(OP_TICK, 8'h00, 1'b0, 1'b1);
    add_item(OP_TICK, 8'h00, 1'b0, 1'b1);
    drain_bus();

    // First pass runs on the reset acknowledge wait; later passes rewrite it.
    for (int ph = 0; ph <= 8; ph++) begin
      if (ph != 0) write_ack_wait(wait_settings[ph-1]);
      else write_ack_wait(ACK_WAIT_RESET);
      steady = (ph == 4);
      items_queued = 0;
      while (items_queued < PHASE_ITEMS) begin
        case ($urandom_range(0, 5))
          0:       queue_command(OP_START);
          1:       queue_command(OP_STOP);
          2, 3:    queue_command(OP_WRITE);
          default: queue_command(OP_READ);
        endcase
        if (ph == 2 && items_queued > 60 && hold_left == 0 && !hold_req) begin
          hold_req = 1'b1;
        end
      end
      drain_bus();
    end
    steady = 1'b0;

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && bus_results.size() == 0) begin
      $display("i2c_master_bit_sequencer_unit_tb: PASS");
    end else begin
      $display("i2c_master_bit_sequencer_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/i2cms_pkg.sv
hw/rtl/i2cms_core.sv
hw/rtl/i2c_master_bit_sequencer_unit.sv
bench/i2c_master_bit_sequencer_unit_tb.sv
